### hw/rtl/adts_fp_pkg.sv
// Shared types, constants and the sampling-rate table for the ADTS frame parser.
package adts_fp_pkg;

   // Counter width default for the frame and byte counts
   localparam int COUNT_WIDTH_DEF = 32;

   // Header geometry
   localparam int HDR_BYTES = 7;
   localparam int LEN_WIDTH = 13;
   localparam logic [LEN_WIDTH-1:0] HDR_LEN     = LEN_WIDTH'(HDR_BYTES);
   localparam logic [LEN_WIDTH-1:0] HDR_LAST    = LEN_WIDTH'(HDR_BYTES - 1);
   localparam logic [LEN_WIDTH-1:0] POS_SYNC0   = LEN_WIDTH'(0);
   localparam logic [LEN_WIDTH-1:0] POS_SYNC1   = LEN_WIDTH'(1);

   // Sync word checks
   localparam logic [7:0] SYNC_BYTE0 = 8'hFF;
   localparam logic [7:0] SYNC_MASK1 = 8'hF6;
   localparam logic [7:0] SYNC_BYTE1 = 8'hF0;

   // Result status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_SYNC  = 2'd1;
   localparam logic [1:0] STATUS_SHORT = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       new_stream;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        mpeg_id;
      logic        crc_absent;
      logic [1:0]  profile;
      logic [3:0]  rate_index;
      logic [16:0] sample_rate_hz;
      logic [2:0]  channel_config;
      logic [12:0] frame_bytes;
      logic [10:0] buffer_fullness;
      logic [1:0]  raw_blocks;
      logic [31:0] frame_index;
      logic [31:0] byte_total;
   } rsp_type;

   // Sampling frequency table, reserved indices read as zero
   function automatic logic [16:0] rate_lookup(input logic [3:0] idx);
      logic [16:0] hz;
      case (idx)
         4'd0:    hz = 17'd96000;
         4'd1:    hz = 17'd88200;
         4'd2:    hz = 17'd64000;
         4'd3:    hz = 17'd48000;
         4'd4:    hz = 17'd44100;
         4'd5:    hz = 17'd32000;
         4'd6:    hz = 17'd24000;
         4'd7:    hz = 17'd22050;
         4'd8:    hz = 17'd16000;
         4'd9:    hz = 17'd12000;
         4'd10:   hz = 17'd11025;
         4'd11:   hz = 17'd8000;
         4'd12:   hz = 17'd7350;
         default: hz = 17'd0;
      endcase
      return hz;
   endfunction

endpackage

### hw/rtl/adts_fp_decode.sv
// Field extraction from the six stored header bytes plus the seventh byte.
module adts_fp_decode
   import adts_fp_pkg::*;
(
   input  logic [47:0]          hdr_bytes,
   input  logic [7:0]           last_byte,
   output rsp_type              fields,
   output logic [LEN_WIDTH-1:0] frame_len
);

   logic [7:0] h1, h2, h3, h4, h5;

   assign h1 = hdr_bytes[39:32];
   assign h2 = hdr_bytes[31:24];
   assign h3 = hdr_bytes[23:16];
   assign h4 = hdr_bytes[15:8];
   assign h5 = hdr_bytes[7:0];

   assign frame_len = {h3[1:0], h4, h5[7:5]};

   // ISO bit layout; counters are filled in by the top level
   always_comb begin
      fields                 = '0;
      fields.status          = STATUS_OK;
      fields.mpeg_id         = h1[3];
      fields.crc_absent      = h1[0];
      fields.profile         = h2[7:6];
      fields.rate_index      = h2[5:2];
      fields.sample_rate_hz  = rate_lookup(h2[5:2]);
      fields.channel_config  = {h2[0], h3[7:6]};
      fields.frame_bytes     = frame_len;
      fields.buffer_fullness = {h5[4:0], last_byte[7:2]};
      fields.raw_blocks      = last_byte[1:0];
   end

endmodule

### hw/rtl/adts_frame_parser.sv
// ADTS frame parser top level: byte input stage, parse state, result register.
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+------------------------------
//   req_    | in  | req_valid / req_stall  | req_data  (req_type)
//   rsp_    | out | rsp_valid / rsp_stall  | rsp_data  (rsp_type)
//
// One byte per cycle unless a stalled result holds a byte; a taken byte waits in
// the input stage until it is parsed into the result register that offers it.
// Reset is synchronous and clears the parse state and both valid flags.
// A stalled result blocks only bytes that produce a result; payload bytes keep
// flowing. req_stall follows rsp_stall in the same cycle through the input stage.
module adts_frame_parser
   import adts_fp_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef enum logic [2:0] {
      PH_HEADER  = 3'b001,
      PH_PAYLOAD = 3'b010,
      PH_HALTED  = 3'b100
   } phase_type;

   // Input stage
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;

   // Parse state
   phase_type              phase_ff, phase_in;
   logic [LEN_WIDTH-1:0]   pos_ff, pos_in;
   logic [47:0]            hdr_ff, hdr_in;
   logic [LEN_WIDTH-1:0]   len_ff, len_in;
   logic [COUNT_WIDTH-1:0] frames_ff, frames_in;
   logic [COUNT_WIDTH-1:0] bytes_ff, bytes_in;

   // Result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   // Working signals
   phase_type              eff_phase;
   logic [LEN_WIDTH-1:0]   eff_pos, eff_len, pos_next;
   logic [47:0]            eff_hdr;
   logic [COUNT_WIDTH-1:0] eff_frames, eff_bytes;
   logic [COUNT_WIDTH:0]   byte_sum;
   logic [7:0]             cur_byte;
   rsp_type                dec_fields, result;
   logic [LEN_WIDTH-1:0]   dec_len;
   logic                   has_result, out_free, advance;

   adts_fp_decode u_decode (
      .hdr_bytes (eff_hdr),
      .last_byte (cur_byte),
      .fields    (dec_fields),
      .frame_len (dec_len)
   );

   // Handshake between the stages
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!has_result || out_free);
   assign req_stall = in_valid_ff && !advance;

   // New-stream flag clears state ahead of the byte it travels with
   assign cur_byte   = in_data_ff.data_byte;
   assign eff_phase  = in_data_ff.new_stream ? PH_HEADER : phase_ff;
   assign eff_pos    = in_data_ff.new_stream ? '0 : pos_ff;
   assign eff_hdr    = in_data_ff.new_stream ? '0 : hdr_ff;
   assign eff_len    = in_data_ff.new_stream ? '0 : len_ff;
   assign eff_frames = in_data_ff.new_stream ? '0 : frames_ff;
   assign eff_bytes  = in_data_ff.new_stream ? '0 : bytes_ff;

   assign pos_next = eff_pos + LEN_WIDTH'(1);
   assign byte_sum = {1'b0, eff_bytes} + {{(COUNT_WIDTH-LEN_WIDTH+1){1'b0}}, dec_len};

   // Parse step for the byte in the input stage
   always_comb begin
      phase_in   = eff_phase;
      pos_in     = eff_pos;
      hdr_in     = eff_hdr;
      len_in     = eff_len;
      frames_in  = eff_frames;
      bytes_in   = eff_bytes;
      has_result = 1'b0;
      result             = dec_fields;
      result.frame_index = 32'(eff_frames);
      result.byte_total  = 32'(eff_bytes);
      case (eff_phase)
         PH_PAYLOAD: begin
            pos_in = pos_next;
            if (pos_next >= eff_len) begin
               phase_in = PH_HEADER;
               pos_in   = '0;
            end
         end
         PH_HEADER: begin
            if ((eff_pos == POS_SYNC0 && cur_byte != SYNC_BYTE0) ||
                (eff_pos == POS_SYNC1 && (cur_byte & SYNC_MASK1) != SYNC_BYTE1)) begin
               // sync lost: header fields read as zero
               has_result         = 1'b1;
               result             = '0;
               result.status      = STATUS_SYNC;
               result.frame_index = 32'(eff_frames);
               result.byte_total  = 32'(eff_bytes);
               phase_in           = PH_HALTED;
            end else if (eff_pos < HDR_LAST) begin
               hdr_in = {eff_hdr[39:0], cur_byte};
               pos_in = pos_next;
            end else begin
               has_result = 1'b1;
               if (dec_len < HDR_LEN) begin
                  result.status = STATUS_SHORT;
                  phase_in      = PH_HALTED;
               end else begin
                  frames_in = (&eff_frames) ? eff_frames
                                            : eff_frames + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
                  bytes_in  = byte_sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}}
                                                    : byte_sum[COUNT_WIDTH-1:0];
                  result.byte_total = 32'(bytes_in);
                  hdr_in = '0;
                  if (dec_len == HDR_LEN) begin
                     phase_in = PH_HEADER;
                     pos_in   = '0;
                  end else begin
                     phase_in = PH_PAYLOAD;
                     pos_in   = HDR_LEN;
                     len_in   = dec_len;
                  end
               end
            end
         end
         PH_HALTED: begin
            phase_in = PH_HALTED;
         end
         default: begin
            phase_in = PH_HALTED;
         end
      endcase
   end

   // Valid flags for the two stages
   assign in_valid_in  = req_stall ? 1'b1 : req_valid;
   assign rsp_valid_in = (advance && has_result) ? 1'b1 : (rsp_valid_ff && rsp_stall);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_HEADER;
         pos_ff       <= '0;
         frames_ff    <= '0;
         bytes_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            phase_ff  <= phase_in;
            pos_ff    <= pos_in;
            frames_ff <= frames_in;
            bytes_ff  <= bytes_in;
         end
      end
   end

   // Header and length registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff <= '0;
         len_ff <= '0;
      end else if (advance) begin
         hdr_ff <= hdr_in;
         len_ff <= len_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (advance && has_result) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Header collection never runs past the seventh header byte
   a_hdr_pos: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HEADER |-> pos_ff < HDR_LEN)
      else $error("header position out of range");

   // Payload skip stays inside a frame longer than its header
   a_payload_pos: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> (pos_ff < len_ff && len_ff > HDR_LEN))
      else $error("payload position beyond frame length");

   // Every error result leaves the parser halted
   a_err_halt: assert property (@(posedge clock) disable iff (reset)
      (advance && has_result && result.status != STATUS_OK) |=> phase_ff == PH_HALTED)
      else $error("parser not halted after error");

endmodule
